@@ rtl/core/oli_pkg.sv @@
// ----------------------------------------------------------------------------
// oli_pkg
// Shared types and constants for the bounded ordered list: operation and
// status codes, field widths and the per-cycle control word seen by each cell.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int unsigned ValueW    = 16;
    localparam int unsigned OpW       = 2;
    localparam int unsigned PosW      = 7;
    localparam int unsigned StatusW   = 2;
    localparam int unsigned CountOutW = 7;
    localparam int unsigned DefCapacity = 64;

    localparam logic [OpW-1:0] OpPushFront = 2'd0;
    localparam logic [OpW-1:0] OpAppend    = 2'd1;
    localparam logic [OpW-1:0] OpInsert    = 2'd2;
    localparam logic [OpW-1:0] OpPopFront  = 2'd3;

    localparam logic [StatusW-1:0] StatOk    = 2'd0;
    localparam logic [StatusW-1:0] StatEmpty = 2'd1;
    localparam logic [StatusW-1:0] StatFull  = 2'd2;

    localparam logic [ValueW-1:0] EmptyPopValue = 16'hFFFF;

    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [ValueW-1:0] value;
    } t_cell_ctrl;

endpackage

@@ rtl/core/oli_cell.sv @@
// ----------------------------------------------------------------------------
// oli_cell
// One list slot. Holds one entry and, on each accepted beat, takes the new
// value, the left neighbour's entry (insert shift) or the right neighbour's
// entry (pop shift), or holds.
// ----------------------------------------------------------------------------
module oli_cell
    import oli_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 7
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CNT_W-1:0]  i_idx,
    input  logic [ValueW-1:0] i_left,
    input  logic [ValueW-1:0] i_right,
    output logic [ValueW-1:0] o_value
);

    logic [ValueW-1:0] r_entry;
    logic [ValueW-1:0] n_entry;

    localparam logic [CNT_W-1:0] MyIndex = CNT_W'(INDEX);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_entry = i_right;
        end else if (i_ctrl.ins) begin
            if (MyIndex == i_idx) begin
                n_entry = i_ctrl.value;
            end else if (MyIndex > i_idx) begin
                n_entry = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_value = r_entry;

endmodule

@@ rtl/core/ordered_list_insert_pop_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_pop_top
// Bounded ordered list of signed 16-bit values held in a row of cells:
// push front, append back, insert at position, pop front.
//
//   channel  dir  tdata (low bit up)                          tuser
//   s_axis   in   item_value[15:0] position[22:16]            operation[1:0]
//   m_axis   out  popped_value[15:0] status[17:16]            -
//                 entry_count[24:18] is_empty[25]
//
// One operation per cycle while the output register can take its result:
// every cell compares its index with the insert point and shifts locally in
// the accept cycle; the result is registered in a single output register. A
// new beat is taken whenever that register is empty or is being drained.
// Synchronous active-low reset empties the list; entry contents are not reset.
// ----------------------------------------------------------------------------
module ordered_list_insert_pop_top
    import oli_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // item_value, position, zero pad
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // popped_value, status, entry_count,
                                        // is_empty, zero pad
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MW = (CW > PosW) ? CW : PosW;
    localparam logic [CW-1:0] Full = CW'(CAPACITY);

    logic [OpW-1:0]    op;
    logic [ValueW-1:0] val;
    logic [PosW-1:0]   pos;
    logic              accept;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    logic [ValueW-1:0] r_popped;
    logic [StatusW-1:0] r_status;
    logic [CountOutW-1:0] r_cnt_out;
    logic              r_empty;

    logic [ValueW-1:0] n_popped;
    logic [StatusW-1:0] n_status;
    logic [CW-1:0]     idx;
    logic [MW-1:0]     pos_ext;
    logic [MW-1:0]     cnt_ext;
    logic [MW-1:0]     n_cnt_ext;
    t_cell_ctrl        ctrl;

    logic [ValueW-1:0] cell_val [CAPACITY];

    assign op  = s_axis_tuser;
    assign val = s_axis_tdata[15:0];
    assign pos = s_axis_tdata[22:16];

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pos_ext = MW'(pos);
    assign cnt_ext = MW'(r_count);

    always_comb begin
        ctrl       = '0;
        ctrl.value = val;
        idx        = r_count;
        n_count    = r_count;
        n_popped   = '0;
        n_status   = StatOk;
        case (op)
            OpPopFront: begin
                if (r_count == '0) begin
                    n_popped = EmptyPopValue;
                    n_status = StatEmpty;
                end else begin
                    n_popped = cell_val[0];
                    ctrl.pop = accept;
                    n_count  = r_count - CW'(1);
                end
            end
            OpPushFront, OpAppend, OpInsert: begin
                if (r_count == Full) begin
                    n_status = StatFull;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CW'(1);
                    if (op == OpPushFront) begin
                        idx = '0;
                    end else if (op == OpInsert && pos_ext < cnt_ext) begin
                        idx = CW'(pos_ext);
                    end
                end
            end
            default: begin
                n_status = StatOk;
            end
        endcase
    end

    assign n_cnt_ext = MW'(n_count);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ValueW-1:0] left_v;
            logic [ValueW-1:0] right_v;
            if (g == 0) begin : g_first
                assign left_v = cell_val[0];
            end else begin : g_mid_l
                assign left_v = cell_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_v = cell_val[g];
            end else begin : g_mid_r
                assign right_v = cell_val[g+1];
            end
            oli_cell #(
                .INDEX (g),
                .CNT_W (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_idx   (idx),
                .i_left  (left_v),
                .i_right (right_v),
                .o_value (cell_val[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped  <= n_popped;
            r_status  <= n_status;
            r_cnt_out <= n_cnt_ext[CountOutW-1:0];
            r_empty   <= (n_count == '0);
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'd0, r_empty, r_cnt_out, r_status, r_popped};

    property p_count_bounded;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= Full;
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("entry count above capacity");

    property p_full_drop_keeps_count;
        @(posedge i_clk) disable iff (!i_rst_n)
            (accept && op != OpPopFront && r_count == Full)
            |=> (r_count == Full && r_status == StatFull);
    endproperty
    a_full_drop_keeps_count: assert property (p_full_drop_keeps_count)
        else $error("dropped insert changed the list");

    property p_pop_decrements;
        @(posedge i_clk) disable iff (!i_rst_n)
            (accept && op == OpPopFront && r_count != '0)
            |=> (r_count == $past(r_count) - CW'(1) && r_status == StatOk);
    endproperty
    a_pop_decrements: assert property (p_pop_decrements)
        else $error("pop did not remove exactly one entry");

    property p_empty_flag;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_valid |-> (r_empty == (r_count == '0));
    endproperty
    a_empty_flag: assert property (p_empty_flag)
        else $error("empty flag disagrees with count");

endmodule

@@ tb/ordered_list_insert_pop_checker.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_pop_checker
// Watches both stream channels of the ordered list. Keeps its own copy of the
// list, works out the result of every accepted operation and compares each
// result beat, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ordered_list_insert_pop_checker
    import oli_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // item_value, position, zero pad
    input  logic [1:0]  s_axis_tuser,   // operation
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // popped_value, status, entry_count,
                                        // is_empty, zero pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_drops,
    output int          o_empty_pops,
    output int          o_peak_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [ValueW-1:0] popped;
        logic [StatusW-1:0]       status;
        logic [CountOutW-1:0]     count;
        logic                     empty;
    } t_list_result;

    logic [ValueW-1:0] list_vals [CAPACITY];
    int                list_len;
    t_list_result      pending_results [$];
    int                fail_cnt;
    int                checked_cnt;
    int                full_cnt;
    int                empty_cnt;
    int                peak_len;

    task automatic apply_list_op(input logic [OpW-1:0] op, input logic [ValueW-1:0] val,
                                 input logic [PosW-1:0] pos, output t_list_result res);
        int idx;
        res = '0;
        res.status = StatOk;
        if (op == OpPopFront) begin
            if (list_len == 0) begin
                res.popped = EmptyPopValue;
                res.status = StatEmpty;
            end else begin
                res.popped = list_vals[0];
                for (int i = 1; i < list_len; i++) list_vals[i-1] = list_vals[i];
                list_len--;
            end
        end else if (list_len >= int'(CAPACITY)) begin
            res.status = StatFull;
        end else begin
            case (op)
                OpPushFront: idx = 0;
                OpAppend:    idx = list_len;
                default:     idx = (int'(pos) < list_len) ? int'(pos) : list_len;
            endcase
            for (int i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
            list_vals[idx] = val;
            list_len++;
        end
        res.count = CountOutW'(list_len);
        res.empty = (list_len == 0);
    endtask

    always @(posedge i_clk) begin
        t_list_result exp_res;
        t_list_result got_res;
        t_list_result new_res;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
            fail_cnt = 0;
            checked_cnt = 0;
            full_cnt = 0;
            empty_cnt = 0;
            peak_len = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res.popped = m_axis_tdata[15:0];
                got_res.status = m_axis_tdata[17:16];
                got_res.count  = m_axis_tdata[24:18];
                got_res.empty  = m_axis_tdata[25];
                if (pending_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("[%0t] unexpected result beat: tdata=%h", $realtime,
                                 m_axis_tdata);
                end else begin
                    exp_res = pending_results.pop_front();
                    checked_cnt++;
                    if (got_res.popped !== exp_res.popped || got_res.status !== exp_res.status
                        || got_res.count !== exp_res.count
                        || got_res.empty !== exp_res.empty) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("[%0t] result %0d mismatch", $realtime, checked_cnt);
                            $display("  exp: popped %0d status %0d count %0d empty %0d",
                                     exp_res.popped, exp_res.status, exp_res.count,
                                     exp_res.empty);
                            $display("  got: popped %0d status %0d count %0d empty %0d",
                                     got_res.popped, got_res.status, got_res.count,
                                     got_res.empty);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_list_op(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[22:16], new_res);
                if (new_res.status == StatFull) full_cnt++;
                if (new_res.status == StatEmpty) empty_cnt++;
                if (list_len > peak_len) peak_len = list_len;
                pending_results.push_back(new_res);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= pending_results.size();
        o_checked    <= checked_cnt;
        o_full_drops <= full_cnt;
        o_empty_pops <= empty_cnt;
        o_peak_count <= peak_len;
    end

endmodule

@@ tb/ordered_list_insert_pop_top_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_pop_top_tb
// Drives operations into the ordered list: a short directed sequence around
// the edges, then random segments that swing the list between full and empty
// under random idling on both channels, with a long output stall and drain
// pauses. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ordered_list_insert_pop_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import oli_pkg::*;

    localparam int StallLimit  = 3000;
    localparam int HoldCycles  = 300;
    localparam int NumSegments = 17;
    localparam int SegmentLen  = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // item_value, position, zero pad
    logic [1:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // popped_value, status, entry_count, is_empty, zero pad

    int fail_count;
    int pending;
    int checked;
    int full_drops;
    int empty_pops;
    int peak_count;

    int   ops_sent [4];
    int   stall_cycles;
    logic tx_idle_on;
    logic rx_idle_on;
    logic rx_hold_req;
    logic rx_hold_done;

    ordered_list_insert_pop_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ordered_list_insert_pop_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_full_drops  (full_drops),
        .o_empty_pops  (empty_pops),
        .o_peak_count  (peak_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= StallLimit) begin
            $display("[%0t] no beat for %0d cycles", $realtime, StallLimit);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        rx_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                rx_hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_op(input logic [OpW-1:0] op, input logic [ValueW-1:0] val,
                           input logic [PosW-1:0] pos);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, pos, val};
        s_axis_tuser  <= op;
        ops_sent[op]++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random_op(input int pop_pct);
        logic [OpW-1:0]    op;
        logic [ValueW-1:0] val;
        logic [PosW-1:0]   pos;
        op = ($urandom_range(0, 99) < pop_pct) ? OpPopFront : OpW'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0:       val = 16'h7FFF;
            1:       val = 16'h8000;
            2:       val = 16'hFFFF;
            3:       val = 16'h0000;
            default: val = ValueW'($urandom);
        endcase
        pos = ($urandom_range(0, 9) == 0) ? PosW'($urandom_range(0, 127))
                                          : PosW'($urandom_range(0, 66));
        send_op(op, val, pos);
    endtask

    initial begin
        int pop_pct;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OpPushFront;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        rx_hold_req   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(OpPopFront,  16'h1111, 7'd0);
        send_op(OpPushFront, 16'h7FFF, 7'd127);
        send_op(OpPushFront, 16'h8000, 7'd0);
        send_op(OpAppend,    16'h0000, 7'd64);
        send_op(OpAppend,    16'hFFFF, 7'd0);
        send_op(OpInsert,    16'h1234, 7'd0);
        send_op(OpInsert,    16'h5555, 7'd2);
        send_op(OpInsert,    16'h0AAA, 7'd64);
        send_op(OpInsert,    16'hFFFE, 7'd127);
        send_op(OpInsert,    16'h0007, 7'd8);
        send_op(OpInsert,    16'hA5A5, 7'd1);
        send_op(OpInsert,    16'h5A5A, 7'd9);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (12) send_op(OpPopFront, 16'h0000, 7'd0);
        send_op(OpPopFront, 16'hFFFF, 7'h7F);
        drain_results();

        for (int seg = 0; seg < NumSegments; seg++) begin
            case (seg)
                0:       pop_pct = 5;
                1:       pop_pct = 95;
                2:       pop_pct = 10;
                default: pop_pct = $urandom_range(5, 95);
            endcase
            tx_idle_on = (seg < NumSegments - 2) && ($urandom_range(0, 2) != 0);
            rx_idle_on = (seg < NumSegments - 2) && ($urandom_range(0, 2) != 0);
            if (seg == 3) begin
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            repeat (SegmentLen) send_random_op(pop_pct);
            if (seg == 2 || $urandom_range(0, 3) == 0) drain_results();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d push, %0d append, %0d insert and %0d pop beats; %0d results checked.",
                 ops_sent[OpPushFront], ops_sent[OpAppend], ops_sent[OpInsert],
                 ops_sent[OpPopFront], checked);
        $display("Peak depth %0d, %0d inserts dropped on full, %0d pops on empty.",
                 peak_count, full_drops, empty_pops);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/oli_pkg.sv
rtl/core/oli_cell.sv
rtl/core/ordered_list_insert_pop_top.sv
tb/ordered_list_insert_pop_checker.sv
tb/ordered_list_insert_pop_top_tb.sv
